// ===== rtl/dorts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRAM open-row timing store package
// Shared types, register indexes and constants for the word store, its
// open-row latency logic and the refresh phase counter.
// ----------------------------------------------------------------------------
package dorts_pkg;

	localparam int WORD_ADDR_BITS_DEF = 16;
	localparam int COLUMN_BITS_DEF    = 8;
	localparam int BYTE_ADDR_W        = 18;
	localparam int DATA_W             = 32;
	localparam int DELAY_W            = 16;
	localparam int LAT_W              = 8;
	localparam int PHASE_W            = 16;
	localparam int CFG_INDEX_W        = 3;
	localparam int CFG_DATA_W         = 16;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_TICK      = 2'd0,
		ST_READ      = 2'd1,
		ST_WRITE     = 2'd2,
		ST_POSTPONED = 2'd3
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OPEN_ROW_MODE     = 3'd0,
		REG_CAS_LATENCY       = 3'd1,
		REG_RAS_TO_CAS_DELAY  = 3'd2,
		REG_PRECHARGE_TIME    = 3'd3,
		REG_REFRESH_ENABLE    = 3'd4,
		REG_REFRESH_INTERVAL  = 3'd5,
		REG_REFRESH_DURATION  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		mode_t                  mode;
		logic [BYTE_ADDR_W-1:0] byte_address;
		logic [DATA_W-1:0]      write_word;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [DATA_W-1:0]    read_word;
		logic [DELAY_W-1:0]   delay_ticks;
		logic                 in_refresh;
	} result_t;

	typedef struct packed {
		logic               enable;
		logic [PHASE_W-1:0] interval;
		logic [PHASE_W-1:0] duration;
	} refresh_cfg_t;

	typedef struct packed {
		logic               active;
		logic               active_next;
		logic [PHASE_W-1:0] remaining;
	} refresh_stat_t;

endpackage

// ===== rtl/dorts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module dorts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/dorts_refresh.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refresh phase counter
// Alternates idle and refresh phases on tick beats and reports the
// remaining length of the current phase.
// ----------------------------------------------------------------------------
module dorts_refresh
	import dorts_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick,
	input  logic          clear,
	input  refresh_cfg_t  cfg,
	output refresh_stat_t stat
);

	logic               active_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] len_raw;
	logic [PHASE_W-1:0] len;
	logic [PHASE_W-1:0] phase_inc;
	logic               wrap;
	logic               advance;

	always_comb begin
		len_raw   = active_q ? cfg.duration : cfg.interval;
		len       = (len_raw == '0) ? PHASE_W'(1) : len_raw;
		phase_inc = phase_q + PHASE_W'(1);
		wrap      = (phase_inc >= len);
		advance   = tick && cfg.enable;

		stat.active      = active_q;
		stat.active_next = (advance && wrap) ? !active_q : active_q;
		stat.remaining   = (len > phase_q) ? (len - phase_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
		end else if (clear) begin
			active_q <= 1'b0;
			phase_q  <= '0;
		end else if (advance) begin
			if (wrap) begin
				active_q <= !active_q;
				phase_q  <= '0;
			end else begin
				phase_q <= phase_inc;
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_idles: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (!active_q && phase_q == '0))
		else $error("refresh state not cleared");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.enable |-> (stat.active_next == active_q))
		else $error("phase flipped while refresh disabled");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !wrap && !clear) |=> (phase_q == $past(phase_inc)))
		else $error("phase counter did not advance");
`endif

endmodule

// ===== rtl/dram_open_row_timing_store_core.sv =====
`timescale 1ns / 1ps
// Latency: a result beat is strobed on done in the cycle after its item is accepted.
// Throughput: one item per cycle; busy stays low, the single RAM port and the
// registered state update set that rate. The receiver cannot stall results.
// Reset clears the open row, first-access flag, refresh phase and registers to
// their defaults; the word store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// DRAM open-row timing store core
// Word store with open-row read latency and periodic refresh postponement.
// ----------------------------------------------------------------------------
module dram_open_row_timing_store_core
	import dorts_pkg::*;
#(
	parameter int WORD_ADDR_BITS = WORD_ADDR_BITS_DEF,
	parameter int COLUMN_BITS    = COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  item_t                  item,
	output logic                   done,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ROW_BITS = (WORD_ADDR_BITS > COLUMN_BITS) ?
		(WORD_ADDR_BITS - COLUMN_BITS) : 1;

	logic                      open_row_mode_q;
	logic [LAT_W-1:0]          cas_q;
	logic [LAT_W-1:0]          rcd_q;
	logic [LAT_W-1:0]          rp_q;
	refresh_cfg_t              rcfg_q;

	logic [ROW_BITS-1:0]       open_row_q;
	logic                      first_q;

	logic                      accept;
	logic                      tick;
	logic                      access;
	logic                      ram_we;
	logic                      refresh_clear;
	logic [WORD_ADDR_BITS-1:0] word_addr;
	logic [WORD_ADDR_BITS-1:0] word_shift;
	logic [ROW_BITS-1:0]       row;
	logic [LAT_W+1:0]          lat;
	status_t                   status_d;
	logic [DELAY_W-1:0]        delay_d;
	refresh_stat_t             rstat;
	logic [DATA_W-1:0]         ram_rdata;

	logic                      done_s1;
	status_t                   status_s1;
	logic [DELAY_W-1:0]        delay_s1;
	logic                      in_refresh_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign word_addr  = item.byte_address[2 +: WORD_ADDR_BITS];
	assign word_shift = word_addr >> COLUMN_BITS;
	assign row        = word_shift[ROW_BITS-1:0];

	assign tick          = accept && (item.mode == MODE_TICK);
	assign access        = accept && !rstat.active &&
		(item.mode == MODE_READ || item.mode == MODE_WRITE);
	assign ram_we        = access && (item.mode == MODE_WRITE);
	assign refresh_clear = cfg_we && (cfg_index == REG_REFRESH_ENABLE) && !cfg_data[0];

	always_comb begin
		if (!open_row_mode_q || first_q) begin
			lat = {2'b00, cas_q} + {2'b00, rcd_q};
		end else if (row == open_row_q) begin
			lat = {2'b00, cas_q};
		end else begin
			lat = {2'b00, cas_q} + {2'b00, rcd_q} + {2'b00, rp_q};
		end

		status_d = ST_TICK;
		delay_d  = '0;
		case (item.mode) inside
			MODE_READ, MODE_WRITE: begin
				if (rstat.active) begin
					status_d = ST_POSTPONED;
					delay_d  = rstat.remaining;
				end else if (item.mode == MODE_READ) begin
					status_d = ST_READ;
					delay_d  = DELAY_W'(lat);
				end else begin
					status_d = ST_WRITE;
				end
			end
			default: begin
				status_d = ST_TICK;
				delay_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_row_mode_q <= 1'b1;
			cas_q           <= LAT_W'(2);
			rcd_q           <= LAT_W'(2);
			rp_q            <= LAT_W'(2);
			rcfg_q.enable   <= 1'b1;
			rcfg_q.interval <= PHASE_W'(1000);
			rcfg_q.duration <= PHASE_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OPEN_ROW_MODE:    open_row_mode_q <= cfg_data[0];
				REG_CAS_LATENCY:      cas_q           <= cfg_data[LAT_W-1:0];
				REG_RAS_TO_CAS_DELAY: rcd_q           <= cfg_data[LAT_W-1:0];
				REG_PRECHARGE_TIME:   rp_q            <= cfg_data[LAT_W-1:0];
				REG_REFRESH_ENABLE:   rcfg_q.enable   <= cfg_data[0];
				REG_REFRESH_INTERVAL: rcfg_q.interval <= cfg_data[PHASE_W-1:0];
				REG_REFRESH_DURATION: rcfg_q.duration <= cfg_data[PHASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_row_q <= '0;
			first_q    <= 1'b1;
			done_s1    <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (access) begin
				open_row_q <= row;
				first_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1     <= status_d;
			delay_s1      <= delay_d;
			in_refresh_s1 <= rstat.active_next;
		end
	end

	dorts_refresh u_refresh (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.clear  (refresh_clear),
		.cfg    (rcfg_q),
		.stat   (rstat)
	);

	dorts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (1 << WORD_ADDR_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (word_addr),
		.wdata (item.write_word),
		.rdata (ram_rdata)
	);

	assign done               = done_s1;
	assign result.status      = status_s1;
	assign result.read_word   = (status_s1 == ST_READ) ? ram_rdata : '0;
	assign result.delay_ticks = delay_s1;
	assign result.in_refresh  = in_refresh_s1;

`ifndef SYNTHESIS
	a_one_beat_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item produced no result beat");

	a_postponed_in_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_s1 == ST_POSTPONED) |-> in_refresh_s1)
		else $error("postponed beat outside refresh");

	a_no_store_in_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		rstat.active |-> !ram_we)
		else $error("store written during refresh");
`endif

endmodule

// ===== dv/dorts_response_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRAM open-row timing store response checker
// Watches the command, result and register ports of the timing store. It
// keeps its own copy of the word store, the open row, the first-access flag
// and the refresh phase. It predicts every result beat and compares it field
// by field with what the core returns.
// ----------------------------------------------------------------------------
module dorts_response_check
	import dorts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  item_t                  item,
	input  logic                   done,
	input  result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     awaited
);

	localparam int ROW_W = WORD_ADDR_BITS_DEF - COLUMN_BITS_DEF;

	logic [DATA_W-1:0]  word_mem [int];
	logic [ROW_W-1:0]   open_row;
	logic               first_access_pending;
	logic               refresh_on;
	logic [PHASE_W-1:0] phase_count;

	logic               row_mode;
	logic [LAT_W-1:0]   cl;
	logic [LAT_W-1:0]   rcd;
	logic [LAT_W-1:0]   rp;
	logic               refresh_allowed;
	logic [PHASE_W-1:0] interval_len;
	logic [PHASE_W-1:0] duration_len;

	result_t            responses_due [$];
	result_t            want;

	function automatic int phase_limit();
		int len;
		len = refresh_on ? duration_len : interval_len;
		return (len == 0) ? 1 : len;
	endfunction

	function automatic result_t dram_response(item_t it);
		result_t                       r;
		logic [WORD_ADDR_BITS_DEF-1:0] word;
		logic [ROW_W-1:0]              row;
		int                            len;
		r = '0;
		word = it.byte_address[BYTE_ADDR_W-1:2];
		row = word[WORD_ADDR_BITS_DEF-1:COLUMN_BITS_DEF];
		case (it.mode) inside
			MODE_TICK: begin
				if (refresh_allowed) begin
					phase_count = phase_count + 1'b1;
					if (phase_count >= phase_limit()) begin
						refresh_on = !refresh_on;
						phase_count = '0;
					end
				end
			end
			MODE_READ, MODE_WRITE: begin
				if (refresh_on) begin
					len = phase_limit();
					r.status = ST_POSTPONED;
					r.delay_ticks = (len > phase_count) ? DELAY_W'(len - phase_count) : '0;
				end else begin
					if (it.mode == MODE_READ) begin
						r.status = ST_READ;
						r.read_word = word_mem.exists(word) ? word_mem[word] : '0;
						if (!row_mode || first_access_pending)
							len = cl + rcd;
						else if (row == open_row)
							len = cl;
						else
							len = cl + rcd + rp;
						r.delay_ticks = len[DELAY_W-1:0];
					end else begin
						r.status = ST_WRITE;
						word_mem[word] = it.write_word;
					end
					open_row = row;
					first_access_pending = 1'b0;
				end
			end
			default: ;
		endcase
		r.in_refresh = refresh_on;
		return r;
	endfunction

	task automatic flag(string field, logic [DATA_W-1:0] want_v, logic [DATA_W-1:0] got_v);
		mismatches = mismatches + 1;
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_row = '0;
			first_access_pending = 1'b1;
			refresh_on = 1'b0;
			phase_count = '0;
			row_mode = 1'b1;
			cl = 8'd2;
			rcd = 8'd2;
			rp = 8'd2;
			refresh_allowed = 1'b1;
			interval_len = 16'd1000;
			duration_len = 16'd50;
			responses_due.delete();
			mismatches = 0;
			awaited <= 0;
		end else begin
			if (done) begin
				if (responses_due.size() == 0) begin
					mismatches = mismatches + 1;
					$display("%0t ns: result beat with nothing expected, actual status %0d",
						$time, result.status);
				end else begin
					want = responses_due.pop_front();
					if (result.status !== want.status)
						flag("status", want.status, result.status);
					if (result.read_word !== want.read_word)
						flag("read_word", want.read_word, result.read_word);
					if (result.delay_ticks !== want.delay_ticks)
						flag("delay_ticks", want.delay_ticks, result.delay_ticks);
					if (result.in_refresh !== want.in_refresh)
						flag("in_refresh", want.in_refresh, result.in_refresh);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_OPEN_ROW_MODE:    row_mode = cfg_data[0];
					REG_CAS_LATENCY:      cl = cfg_data[LAT_W-1:0];
					REG_RAS_TO_CAS_DELAY: rcd = cfg_data[LAT_W-1:0];
					REG_PRECHARGE_TIME:   rp = cfg_data[LAT_W-1:0];
					REG_REFRESH_ENABLE: begin
						refresh_allowed = cfg_data[0];
						if (!cfg_data[0]) begin
							refresh_on = 1'b0;
							phase_count = '0;
						end
					end
					REG_REFRESH_INTERVAL: interval_len = cfg_data;
					REG_REFRESH_DURATION: duration_len = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				responses_due.push_back(dram_response(item));
			awaited <= responses_due.size();
		end
	end

endmodule

// ===== dv/dram_open_row_timing_store_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRAM open-row timing store core testbench
// Drives commands and register writes into the timing store. A directed
// sequence covers the latency extremes, row hits and misses, unaligned and
// wrapping addresses, zero phase lengths, a phase shortened mid-way and
// refresh switched off while active. Eight random phases follow, each with
// its own register setting and random gaps between beats. Reads only go to
// words whose write has been confirmed. The checker beside the core
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module dram_open_row_timing_store_core_tb;
	import dorts_pkg::*;

	localparam logic [1:0] MODE_NOP_CODE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	item_t                  item = '0;
	logic                   done;
	result_t                result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     mismatches;
	int                     awaited;

	logic [15:0]            issued_words [$];
	logic [15:0]            stored_words [$];
	bit                     stored_seen [int];
	logic [15:0]            done_word;
	bit                     no_gaps = 1'b0;

	dram_open_row_timing_store_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dorts_response_check check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mismatches(mismatches), .awaited(awaited)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done && issued_words.size() > 0) begin
			done_word = issued_words.pop_front();
			if (result.status == ST_WRITE && !stored_seen.exists(done_word)) begin
				stored_seen[done_word] = 1'b1;
				stored_words.push_back(done_word);
			end
		end
	end

	task automatic send_beat(logic [1:0] m, logic [BYTE_ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item.mode <= mode_t'(m);
		item.byte_address <= a;
		item.write_word <= d;
		do @(posedge clk); while (busy);
		issued_words.push_back(a[BYTE_ADDR_W-1:2]);
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		wait (awaited == 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [BYTE_ADDR_W-1:0] pick_write_address();
		logic [7:0] row;
		if ($urandom_range(0, 3) == 0)
			return BYTE_ADDR_W'($urandom);
		case ($urandom_range(0, 3))
			0:       row = 8'h00;
			1:       row = 8'h01;
			2:       row = 8'hFF;
			default: row = 8'($urandom);
		endcase
		return {row, 8'($urandom_range(0, 15)), 2'($urandom)};
	endfunction

	function automatic logic [BYTE_ADDR_W-1:0] pick_read_address();
		int n;
		int k;
		n = stored_words.size();
		if ($urandom_range(0, 9) < 7)
			k = n - 1 - $urandom_range(0, (n > 16) ? 15 : n - 1);
		else
			k = $urandom_range(0, n - 1);
		return {stored_words[k], 2'($urandom)};
	endfunction

	task automatic run_random(int beats);
		int sel;
		repeat (beats) begin
			if ($urandom_range(0, 49) == 0)
				no_gaps = !no_gaps;
			if ($urandom_range(0, 99) == 0)
				settle();
			sel = $urandom_range(0, 99);
			if (sel < 35)
				send_beat(MODE_TICK, BYTE_ADDR_W'($urandom), $urandom);
			else if (sel < 65 && stored_words.size() > 0)
				send_beat(MODE_READ, pick_read_address(), $urandom);
			else if (sel < 95)
				send_beat(MODE_WRITE, pick_write_address(), $urandom);
			else
				send_beat(MODE_NOP_CODE, BYTE_ADDR_W'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		send_beat(MODE_WRITE, 18'h00000, 32'h0000_0000);
		send_beat(MODE_WRITE, 18'h3FFFF, 32'hFFFF_FFFF);
		send_beat(MODE_READ, 18'h3FFFC, 32'h0);
		send_beat(MODE_READ, 18'h00002, 32'h0);
		send_beat(MODE_WRITE, 18'h00404, 32'hA5A5_A5A5);
		send_beat(MODE_READ, 18'h00405, 32'h0);
		send_beat(MODE_NOP_CODE, 18'h3FFFF, 32'hFFFF_FFFF);
		send_beat(MODE_TICK, 18'h0, 32'h0);

		settle();
		cfg_write(REG_REFRESH_INTERVAL, 16'd0);
		cfg_write(REG_REFRESH_DURATION, 16'd0);
		send_beat(MODE_TICK, 18'h0, 32'h0);
		send_beat(MODE_READ, 18'h00000, 32'h0);
		send_beat(MODE_WRITE, 18'h00008, 32'h1234_5678);
		send_beat(MODE_TICK, 18'h0, 32'h0);

		settle();
		cfg_write(REG_REFRESH_INTERVAL, 16'd65535);
		cfg_write(REG_REFRESH_DURATION, 16'd65535);
		cfg_write(REG_CAS_LATENCY, 16'd255);
		cfg_write(REG_RAS_TO_CAS_DELAY, 16'd255);
		cfg_write(REG_PRECHARGE_TIME, 16'd255);
		send_beat(MODE_READ, 18'h3FFFC, 32'h0);
		send_beat(MODE_READ, 18'h3FFFE, 32'h0);

		settle();
		cfg_write(REG_REFRESH_INTERVAL, 16'd10);
		repeat (4) send_beat(MODE_TICK, 18'h0, 32'h0);
		settle();
		cfg_write(REG_REFRESH_INTERVAL, 16'd2);
		send_beat(MODE_TICK, 18'h0, 32'h0);
		send_beat(MODE_READ, 18'h00404, 32'h0);
		send_beat(MODE_WRITE, 18'h00404, 32'h0F0F_0F0F);

		settle();
		cfg_write(REG_REFRESH_ENABLE, 16'd0);
		send_beat(MODE_READ, 18'h00404, 32'h0);
		send_beat(MODE_TICK, 18'h0, 32'h0);
		settle();
		cfg_write(REG_OPEN_ROW_MODE, 16'd0);
		send_beat(MODE_READ, 18'h00000, 32'h0);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			cfg_write(REG_OPEN_ROW_MODE, (ph % 3 != 2) ? 16'd1 : 16'd0);
			case (ph)
				1: begin
					cfg_write(REG_CAS_LATENCY, 16'd255);
					cfg_write(REG_RAS_TO_CAS_DELAY, 16'd255);
					cfg_write(REG_PRECHARGE_TIME, 16'd255);
				end
				2: begin
					cfg_write(REG_CAS_LATENCY, 16'd0);
					cfg_write(REG_RAS_TO_CAS_DELAY, 16'd0);
					cfg_write(REG_PRECHARGE_TIME, 16'd0);
				end
				default: begin
					cfg_write(REG_CAS_LATENCY, 16'($urandom_range(0, 255)));
					cfg_write(REG_RAS_TO_CAS_DELAY, 16'($urandom_range(0, 255)));
					cfg_write(REG_PRECHARGE_TIME, 16'($urandom_range(0, 255)));
				end
			endcase
			cfg_write(REG_REFRESH_ENABLE, (ph != 3) ? 16'd1 : 16'd0);
			case (ph)
				5: begin
					cfg_write(REG_REFRESH_INTERVAL, 16'd65535);
					cfg_write(REG_REFRESH_DURATION, 16'd1);
				end
				6: begin
					cfg_write(REG_REFRESH_INTERVAL, 16'd4);
					cfg_write(REG_REFRESH_DURATION, 16'd65535);
				end
				default: begin
					cfg_write(REG_REFRESH_INTERVAL, 16'($urandom_range(1, 12)));
					cfg_write(REG_REFRESH_DURATION, 16'($urandom_range(1, 8)));
				end
			endcase
			run_random(200);
		end

		settle();
		repeat (3) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== dram_open_row_timing_store_core.f =====
rtl/dorts_pkg.sv
rtl/dorts_ram.sv
rtl/dorts_refresh.sv
rtl/dram_open_row_timing_store_core.sv
dv/dorts_response_check.sv
dv/dram_open_row_timing_store_core_tb.sv
